>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and tables shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned FillW  = 6;
  localparam int unsigned RoundW = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned BlockW = 512;

  localparam logic [ByteW-1:0]  PadByte   = 8'h80;
  localparam logic [FillW-1:0]  FillFull  = 6'd63;
  localparam logic [FillW-1:0]  FillPadEnd = 6'd55;
  localparam logic [RoundW-1:0] RoundLast = 6'd63;
  localparam logic [IdxW-1:0]   IdxLast   = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_present;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [IdxW-1:0]  word_index;
    logic             last_word;
    logic             length_overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha_state_e;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e byte_sel;
    logic      count_en;
    logic      load_work;
    logic      round_en;
    logic      hash_add;
    logic      out_next;
    logic      clear;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic pad_end;
    logic round_last;
    logic word_last;
  } dp_status_t;

  function automatic logic [WordW-1:0] sha_iv(input logic [IdxW-1:0] idx);
    logic [WordW-1:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] sha_k(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

>>> design/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream; digest leaves as eight 32-bit words.
// ----------------------------------------------------------------------------
// a byte word is taken only while the core is idle; the 64th byte of a block
// starts 64 rounds, then the hash update, set by the single shared round unit
// a last word adds the padding bytes and one or two compressions, then
// eight digest words at one per cycle while out_ready_i is high
// reset (async, active low) loads the initial hash and clears all counters
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sha_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: byte shift buffer doubling as message schedule window, round
// logic, hash state, byte counter and digest word selection.
// ----------------------------------------------------------------------------
module sha_dp
  import sha_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ByteW-1:0] data_byte_i,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  output out_t             out_data_o
);

  logic [BlockW-1:0] buf_q, buf_d;
  logic [WordW-1:0]  work_q [8];
  logic [WordW-1:0]  work_d [8];
  logic [WordW-1:0]  hash_q [8];
  logic [FillW-1:0]  fill_q;
  logic [CountW-1:0] total_q;
  logic              ovf_q;
  logic [RoundW-1:0] round_q;
  logic [IdxW-1:0]   idx_q;

  logic [63:0]      len_bits;
  logic [IdxW-1:0]  len_sel;
  logic [ByteW-1:0] len_byte;
  logic [ByteW-1:0] shift_byte;

  logic [WordW-1:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [WordW-1:0] a, e, big_s0, big_s1, ch, maj, t1, t2;

  function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  // length bytes leave most significant first while fill runs 56..63
  assign len_bits = {total_q, 3'b000};
  assign len_sel  = IdxLast - fill_q[IdxW-1:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_DATA: shift_byte = data_byte_i;
      BSEL_PAD:  shift_byte = PadByte;
      BSEL_ZERO: shift_byte = '0;
      BSEL_LEN:  shift_byte = len_byte;
      default:   shift_byte = '0;
    endcase
  end

  // schedule window taps: w0 is the word used in this round
  assign w0  = buf_q[511:480];
  assign w1  = buf_q[479:448];
  assign w9  = buf_q[223:192];
  assign w14 = buf_q[63:32];
  assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign a      = work_q[0];
  assign e      = work_q[4];
  assign big_s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
  assign big_s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
  assign ch     = (e & work_q[5]) ^ (~e & work_q[6]);
  assign maj    = (a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1     = work_q[7] + big_s1 + ch + sha_k(round_q) + w0;
  assign t2     = big_s0 + maj;

  always_comb begin
    buf_d = buf_q;
    if (cmd_i.shift_en) begin
      buf_d = {buf_q[BlockW-ByteW-1:0], shift_byte};
    end else if (cmd_i.round_en) begin
      buf_d = {buf_q[BlockW-WordW-1:0], w_new};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      work_d[i] = work_q[i];
    end
    if (cmd_i.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work_d[i] = hash_q[i];
      end
    end else if (cmd_i.round_en) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    for (int i = 0; i < 8; i++) begin
      work_q[i] <= work_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      round_q <= '0;
      idx_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha_iv(IdxW'(i));
      end
    end else begin
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.count_en) begin
        // saturate at 2^61-1 and flag it
        if (&total_q) begin
          ovf_q <= 1'b1;
        end else begin
          total_q <= total_q + 1'b1;
        end
      end
      if (cmd_i.load_work) begin
        round_q <= '0;
      end else if (cmd_i.round_en) begin
        round_q <= round_q + 1'b1;
      end
      if (cmd_i.hash_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + work_q[i];
        end
      end
      if (cmd_i.out_next) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.clear) begin
        fill_q  <= '0;
        total_q <= '0;
        ovf_q   <= 1'b0;
        idx_q   <= '0;
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= sha_iv(IdxW'(i));
        end
      end
    end
  end

  assign status_o.fill_last  = (fill_q == FillFull);
  assign status_o.pad_end    = (fill_q == FillPadEnd);
  assign status_o.round_last = (round_q == RoundLast);
  assign status_o.word_last  = (idx_q == IdxLast);

  assign out_data_o.digest_word     = hash_q[idx_q];
  assign out_data_o.word_index      = idx_q;
  assign out_data_o.last_word       = (idx_q == IdxLast);
  assign out_data_o.length_overflow = ovf_q;

endmodule

>>> design/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: byte intake, padding sequence, round loop and digest readout.
// ----------------------------------------------------------------------------
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_t        in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  sha_state_e state_q, state_d;
  sha_state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cmd_o       = '0;
    cmd_o.byte_sel = BSEL_DATA;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            cmd_o.shift_en = 1'b1;
            cmd_o.count_en = 1'b1;
            if (status_i.fill_last) begin
              // block complete: compress, then pad if the word also ends the message
              cmd_o.load_work = 1'b1;
              state_d = ST_ROUND;
              ret_d   = in_data_i.last ? ST_PAD80 : ST_IDLE;
            end else if (in_data_i.last) begin
              state_d = ST_PAD80;
            end
          end else if (in_data_i.last) begin
            state_d = ST_PAD80;
          end
        end
      end

      ST_PAD80: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = BSEL_PAD;
        if (status_i.fill_last) begin
          cmd_o.load_work = 1'b1;
          state_d = ST_ROUND;
          ret_d   = ST_PADZ;
        end else if (status_i.pad_end) begin
          state_d = ST_PADLEN;
        end else begin
          state_d = ST_PADZ;
        end
      end

      ST_PADZ: begin
        // an empty block after a compression goes straight to zero fill too
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = BSEL_ZERO;
        if (status_i.fill_last) begin
          cmd_o.load_work = 1'b1;
          state_d = ST_ROUND;
          ret_d   = ST_PADZ;
        end else if (status_i.pad_end) begin
          state_d = ST_PADLEN;
        end
      end

      ST_PADLEN: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = BSEL_LEN;
        if (status_i.fill_last) begin
          cmd_o.load_work = 1'b1;
          state_d = ST_ROUND;
          ret_d   = ST_OUT;
        end
      end

      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (status_i.round_last) begin
          state_d = ST_ADD;
        end
      end

      ST_ADD: begin
        cmd_o.hash_add = 1'b1;
        state_d = ret_q;
      end

      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          if (status_i.word_last) begin
            cmd_o.clear = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha256_stream_hasher_core: byte words go in under
// random pacing, and a software SHA-256 predicts the eight digest words of
// every message, which are compared field by field as they leave the block.
// ----------------------------------------------------------------------------

localparam logic [31:0] ROUND_K [64] = '{
  32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
  32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
  32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
  32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
  32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
  32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
  32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
  32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
  32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
  32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
  32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
  32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
  32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

localparam logic [31:0] START_HASH [8] = '{
  32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

localparam logic [7:0] PAD_MARK = 8'h80;

class digest_scoreboard;
  logic [31:0]     chain [8];
  logic [7:0]      blk [64];
  int unsigned     fill;
  logic [60:0]     msg_bytes;
  bit              saturated;
  sha_pkg::out_t   digest_q [$];
  int unsigned     errors;
  int unsigned     words_checked;
  int unsigned     messages;
  int unsigned     bytes_taken;

  function new();
    errors = 0;
    words_checked = 0;
    messages = 0;
    bytes_taken = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
    fill = 0;
    msg_bytes = '0;
    saturated = 1'b0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, wr;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s1 = ror(w[(r-2) & 15], 17) ^ ror(w[(r-2) & 15], 19) ^ (w[(r-2) & 15] >> 10);
        s0 = ror(w[(r-15) & 15], 7) ^ ror(w[(r-15) & 15], 18) ^ (w[(r-15) & 15] >> 3);
        wr = s1 + w[(r-7) & 15] + s0 + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function void note_input(sha_pkg::in_t w);
    logic [63:0]   bit_len;
    sha_pkg::out_t e;
    if (w.byte_present) begin
      bytes_taken++;
      // count saturates at 2^61-1
      if (msg_bytes == '1) saturated = 1'b1;
      else msg_bytes = msg_bytes + 1'b1;
      blk[fill] = w.data_byte;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!w.last) return;
    blk[fill] = PAD_MARK;
    fill++;
    // no room for the length field, spill into one more block
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) blk[i] = 8'h00;
      compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) blk[i] = 8'h00;
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      e.digest_word     = chain[i];
      e.word_index      = 3'(i);
      e.last_word       = (i == 7);
      e.length_overflow = saturated;
      digest_q = {digest_q, e};
    end
    messages++;
    restart();
  endfunction

  function void check_result(sha_pkg::out_t got);
    sha_pkg::out_t want;
    if (digest_q.size() == 0) begin
      $error("unexpected digest word %h", got);
      errors++;
      return;
    end
    want = digest_q.pop_front();
    words_checked++;
    if (got.digest_word !== want.digest_word) begin
      $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
      errors++;
    end
    if (got.last_word !== want.last_word) begin
      $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
      errors++;
    end
    if (got.length_overflow !== want.length_overflow) begin
      $error("length_overflow: expected %0b, actual %0b",
             want.length_overflow, got.length_overflow);
      errors++;
    end
  endfunction
endclass

module tb;
  import sha_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 170;
  localparam int unsigned CALM_AFTER   = 135;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  digest_scoreboard sb = new();
  bit               wind_down;
  int unsigned      cycle_count;
  int unsigned      random_words;

  sha256_stream_hasher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sha256_stream_hasher_core verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // output side: ready runs with random stall bursts, none while winding down
  initial begin
    out_ready_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 30)) @(negedge clk_i) out_ready_i <= 1'b1;
      if (!wind_down && $urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 13)) @(negedge clk_i) out_ready_i <= 1'b0;
    end
  end

  task automatic send_word(input in_t w);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(w);
  endtask

  task automatic make_word(input logic [7:0] b, input logic present, input logic fin,
                           output in_t w);
    w.data_byte    = b;
    w.byte_present = present;
    w.last         = fin;
  endtask

  task automatic idle_burst(input int unsigned pct);
    int unsigned n;
    n = $urandom_range(1, 13);
    if (!wind_down && $urandom_range(0, 99) < pct) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_digests_drained();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk_i);
  endtask

  // one message of random bytes, the end marked on the final byte or alone
  task automatic send_message(input int unsigned nbytes, input bit last_alone,
                              input int unsigned pct);
    in_t w;
    for (int unsigned k = 0; k < nbytes; k++) begin
      idle_burst(pct);
      if ($urandom_range(0, 9) == 0) begin
        make_word(8'($urandom), 1'b0, 1'b0, w);
        send_word(w);
        random_words++;
      end
      make_word(8'($urandom), 1'b1, !last_alone && (k == nbytes - 1), w);
      send_word(w);
      random_words++;
    end
    if (last_alone || nbytes == 0) begin
      idle_burst(pct);
      make_word(8'($urandom), 1'b0, 1'b1, w);
      send_word(w);
      random_words++;
    end
  endtask

  initial begin
    in_t         w;
    int unsigned len;
    int unsigned pct;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    wind_down    = 1'b0;
    cycle_count  = 0;
    random_words = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // empty message, end word carries no byte
    make_word(8'hff, 1'b0, 1'b1, w); send_word(w);
    // ignored word
    make_word(8'h00, 1'b0, 1'b0, w); send_word(w);
    // "abc", end marked on the byte
    make_word(8'h61, 1'b1, 1'b0, w); send_word(w);
    make_word(8'h62, 1'b1, 1'b0, w); send_word(w);
    make_word(8'h63, 1'b1, 1'b1, w); send_word(w);
    // byte extremes, then end alone
    make_word(8'hff, 1'b1, 1'b0, w); send_word(w);
    make_word(8'h00, 1'b1, 1'b0, w); send_word(w);
    make_word(8'hff, 1'b0, 1'b0, w); send_word(w);
    make_word(8'h5a, 1'b0, 1'b1, w); send_word(w);
    // single zero byte with end
    make_word(8'h00, 1'b1, 1'b1, w); send_word(w);
    make_word(8'h00, 1'b0, 1'b1, w); send_word(w);
    wait_digests_drained();

    while (random_words < RANDOM_WORDS) begin
      if (random_words >= CALM_AFTER) wind_down = 1'b1;
      case ($urandom_range(0, 2))
        0:       pct = 0;
        1:       pct = 10;
        default: pct = 35;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
        6, 7, 8:          len = $urandom_range(52, 66);  // padding boundaries
        default:          len = $urandom_range(100, 130);
      endcase
      // keep the total word count near the planned size
      if (len > RANDOM_WORDS - random_words) len = RANDOM_WORDS - random_words;
      send_message(len, $urandom_range(0, 1), pct);
      if ($urandom_range(0, 5) == 0) wait_digests_drained();
    end

    wait_digests_drained();
    repeat (300) @(posedge clk_i);
    $display("run covered %0d messages built from %0d message bytes",
             sb.messages, sb.bytes_taken);
    $display("%0d digest words compared, %0d mismatches", sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("sha256_stream_hasher_core verification clean");
    end else begin
      $display("sha256_stream_hasher_core verification failed");
    end
    $finish;
  end

endmodule
